FILE: rtl/key_value_line_tokenizer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the key/value line tokenizer
// Concurrent checks clocked on the rising edge and held off during reset.
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_LINE_TOKENIZER_ASSERT_SVH
`define KEY_VALUE_LINE_TOKENIZER_ASSERT_SVH

`ifndef SYNTHESIS

// property that must hold at every edge out of reset
`define KVLT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequence that must hold after the antecedent, as a non-overlapping implication
`define KVLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define KVLT_ASSERT(label, clk, rst_n, prop, msg)
`define KVLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/kvlt_pkg.sv
// ----------------------------------------------------------------------------
// kvlt_pkg
// Widths, codes, result record and character class helpers of the tokenizer.
// ----------------------------------------------------------------------------
package kvlt_pkg;

    localparam int MAX_FILE_BYTES = 1048576;
    localparam int OFFSET_W       = $clog2(MAX_FILE_BYTES + 1);
    localparam logic [OFFSET_W-1:0] MAX_OFF = OFFSET_W'(MAX_FILE_BYTES);

    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 2;
    localparam int CODE_W   = 3;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [BYTE_W-1:0] CHAR_HASH = 8'h23;
    localparam logic [BYTE_W-1:0] CHAR_NL   = 8'h0A;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAIR  = 2'd0,
        KIND_ERROR = 2'd1,
        KIND_DONE  = 2'd2
    } t_kind;

    typedef enum logic [CODE_W-1:0] {
        ERR_PRE_KEY  = 3'd0,
        ERR_NO_VALUE = 3'd1,
        ERR_KEY_BYTE = 3'd2,
        ERR_PRE_ARG  = 3'd3,
        ERR_ARG_BYTE = 3'd4
    } t_err;

    typedef enum logic [5:0] {
        MODE_PRE  = 6'b000001,
        MODE_KEY  = 6'b000010,
        MODE_GAP  = 6'b000100,
        MODE_ARG  = 6'b001000,
        MODE_TAIL = 6'b010000,
        MODE_HALT = 6'b100000
    } t_mode;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [OFFSET_W-1:0] key_begin;
        logic [OFFSET_W-1:0] key_finish;
        logic [OFFSET_W-1:0] arg_begin;
        logic [OFFSET_W-1:0] arg_finish;
        logic [CODE_W-1:0]   code;
        logic [OFFSET_W-1:0] line;
        logic [OFFSET_W-1:0] column;
        logic                last;
    } t_result;

    function automatic logic [OFFSET_W-1:0] sat_inc(input logic [OFFSET_W-1:0] v);
        return (v >= MAX_OFF) ? MAX_OFF : v + OFFSET_W'(1);
    endfunction

    function automatic logic is_graph(input logic [BYTE_W-1:0] b);
        return b inside {[8'h21:8'h7E]};
    endfunction

    function automatic logic is_space(input logic [BYTE_W-1:0] b);
        return b inside {[8'h09:8'h0D], 8'h20};
    endfunction

endpackage

FILE: rtl/key_value_line_tokenizer.sv
// ----------------------------------------------------------------------------
// key_value_line_tokenizer
// Scans a text one byte per request, reports key/argument offsets per line,
// syntax errors with line and column, and a done record at end of file
// unless the file had an error.
//  channel   direction  handshake           payload
//  bytes     in         i_valid / o_ready   i_text_byte, i_final_byte
//  results   out        o_valid / i_ready   o_result_kind .. o_last_of_run
//
//  One byte is taken every cycle while o_ready is high; the parse state steps
//  in the same cycle. A byte yields zero, one or two results, written into a
//  four-entry result queue; o_ready is high while the queue holds two entries
//  or fewer, so a two-result byte never overruns it. A slow result side stalls
//  bytes only once the queue holds more than two entries. Synchronous reset
//  returns the parser to the start of a file and empties the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "key_value_line_tokenizer_assert.svh"

module key_value_line_tokenizer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [kvlt_pkg::BYTE_W-1:0]       i_text_byte,
    input  logic                              i_final_byte,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [kvlt_pkg::KIND_W-1:0]       o_result_kind,
    output logic [kvlt_pkg::OFFSET_W-1:0]     o_key_begin,
    output logic [kvlt_pkg::OFFSET_W-1:0]     o_key_finish,
    output logic [kvlt_pkg::OFFSET_W-1:0]     o_arg_begin,
    output logic [kvlt_pkg::OFFSET_W-1:0]     o_arg_finish,
    output logic [kvlt_pkg::CODE_W-1:0]       o_error_code,
    output logic [kvlt_pkg::OFFSET_W-1:0]     o_error_line,
    output logic [kvlt_pkg::OFFSET_W-1:0]     o_error_column,
    output logic                              o_last_of_run
);
    import kvlt_pkg::*;

    // parse state
    t_mode               r_mode, n_mode;
    logic [OFFSET_W-1:0] r_byte_offset, n_byte_offset;
    logic [OFFSET_W-1:0] r_line_number, n_line_number;
    logic [OFFSET_W-1:0] r_line_begin, n_line_begin;
    logic [OFFSET_W-1:0] r_key_start, n_key_start;
    logic [OFFSET_W-1:0] r_key_end, n_key_end;
    logic [OFFSET_W-1:0] r_arg_start, n_arg_start;
    logic [OFFSET_W-1:0] r_arg_last, n_arg_last;

    // result queue
    t_result             r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]    r_count, n_count;

    logic                in_acc;
    logic                out_acc;

    // stepped state, before the end-of-file reset
    t_mode               step_mode;
    logic [OFFSET_W-1:0] step_line_number;
    logic [OFFSET_W-1:0] step_line_begin;
    logic [OFFSET_W-1:0] step_key_start;
    logic [OFFSET_W-1:0] step_key_end;
    logic [OFFSET_W-1:0] step_arg_start;
    logic [OFFSET_W-1:0] step_arg_last;
    logic [OFFSET_W-1:0] off;
    logic [OFFSET_W-1:0] nxt;
    logic                graph, space, nl, hash;
    logic                newline_seen;

    logic                case_v, case_pair;
    t_err                case_code;
    logic                fin_v0, fin_v1;
    t_result             pair_res, done_res, case_res, fin_err_res;
    t_result             fin_res0, fin_res1;
    t_result             res0, res1;
    logic                res0_v, res1_v;

    function automatic t_result make_error(input t_err code,
                                           input logic [OFFSET_W-1:0] pos,
                                           input logic [OFFSET_W-1:0] line,
                                           input logic [OFFSET_W-1:0] lbeg);
        t_result r;
        r        = '0;
        r.kind   = KIND_ERROR;
        r.code   = code;
        r.line   = line;
        r.column = (pos >= lbeg) ? pos - lbeg : '0;
        return r;
    endfunction

    assign in_acc  = i_valid && o_ready;
    assign out_acc = o_valid && i_ready;
    assign o_ready = r_count <= CNT_W'(FIFO_DEPTH - 2);
    assign o_valid = r_count != '0;

    always_comb begin
        off   = r_byte_offset;
        nxt   = sat_inc(off);
        graph = is_graph(i_text_byte);
        space = is_space(i_text_byte);
        nl    = i_text_byte == CHAR_NL;
        hash  = i_text_byte == CHAR_HASH;

        step_mode      = r_mode;
        step_key_start = r_key_start;
        step_key_end   = r_key_end;
        step_arg_start = r_arg_start;
        step_arg_last  = r_arg_last;
        newline_seen   = 1'b0;
        case_v         = 1'b0;
        case_pair      = 1'b0;
        case_code      = ERR_PRE_KEY;

        case (r_mode)
            MODE_PRE: begin
                if (hash) begin
                    step_mode = MODE_TAIL;
                end else if (graph) begin
                    step_mode      = MODE_KEY;
                    step_key_start = off;
                end else if (nl) begin
                    newline_seen = 1'b1;
                end else if (!space) begin
                    case_v    = 1'b1;
                    case_code = ERR_PRE_KEY;
                    step_mode = MODE_HALT;
                end
            end
            MODE_KEY: begin
                if (nl || hash) begin
                    case_v    = 1'b1;
                    case_code = ERR_NO_VALUE;
                    step_mode = MODE_HALT;
                end else if (space) begin
                    step_key_end = off;
                    step_mode    = MODE_GAP;
                end else if (!graph) begin
                    case_v    = 1'b1;
                    case_code = ERR_KEY_BYTE;
                    step_mode = MODE_HALT;
                end
            end
            MODE_GAP: begin
                if (nl || hash) begin
                    case_v    = 1'b1;
                    case_code = ERR_NO_VALUE;
                    step_mode = MODE_HALT;
                end else if (graph) begin
                    step_arg_start = off;
                    step_arg_last  = off;
                    step_mode      = MODE_ARG;
                end else if (!space) begin
                    case_v    = 1'b1;
                    case_code = ERR_PRE_ARG;
                    step_mode = MODE_HALT;
                end
            end
            MODE_ARG: begin
                if (nl) begin
                    case_v       = 1'b1;
                    case_pair    = 1'b1;
                    step_mode    = MODE_PRE;
                    newline_seen = 1'b1;
                end else if (hash) begin
                    case_v    = 1'b1;
                    case_pair = 1'b1;
                    step_mode = MODE_TAIL;
                end else if (graph) begin
                    step_arg_last = off;
                end else if (!space) begin
                    case_v    = 1'b1;
                    case_code = ERR_ARG_BYTE;
                    step_mode = MODE_HALT;
                end
            end
            MODE_TAIL: begin
                if (nl) begin
                    step_mode    = MODE_PRE;
                    newline_seen = 1'b1;
                end
            end
            default: begin
                step_mode = MODE_HALT;
            end
        endcase

        step_line_number = newline_seen ? sat_inc(r_line_number) : r_line_number;
        step_line_begin  = newline_seen ? nxt : r_line_begin;

        // pair fields are untouched on the bytes that close a pair mid-line
        pair_res            = '0;
        pair_res.kind       = KIND_PAIR;
        pair_res.key_begin  = step_key_start;
        pair_res.key_finish = step_key_end;
        pair_res.arg_begin  = step_arg_start;
        pair_res.arg_finish = sat_inc(step_arg_last);

        done_res      = '0;
        done_res.kind = KIND_DONE;

        case_res = case_pair ? pair_res
                             : make_error(case_code, off, step_line_number, step_line_begin);
        fin_err_res = make_error(ERR_NO_VALUE, nxt, step_line_number, step_line_begin);

        // end-of-file records, ordered
        fin_v0   = 1'b0;
        fin_v1   = 1'b0;
        fin_res0 = done_res;
        fin_res1 = done_res;
        if (i_final_byte) begin
            case (step_mode)
                MODE_ARG: begin
                    fin_v0   = 1'b1;
                    fin_v1   = 1'b1;
                    fin_res0 = pair_res;
                end
                MODE_KEY, MODE_GAP: begin
                    fin_v0   = 1'b1;
                    fin_res0 = fin_err_res;
                end
                MODE_PRE, MODE_TAIL: begin
                    fin_v0 = 1'b1;
                end
                default: begin
                    fin_v0 = 1'b0;
                end
            endcase
        end

        res0   = case_v ? case_res : fin_res0;
        res0_v = case_v || fin_v0;
        res1   = case_v ? fin_res0 : fin_res1;
        res1_v = case_v ? fin_v0 : fin_v1;
        res0.last = !res1_v;
        res1.last = 1'b1;

        if (i_final_byte) begin
            n_mode        = MODE_PRE;
            n_byte_offset = '0;
            n_line_number = OFFSET_W'(1);
            n_line_begin  = '0;
            n_key_start   = '0;
            n_key_end     = '0;
            n_arg_start   = '0;
            n_arg_last    = '0;
        end else begin
            n_mode        = step_mode;
            n_byte_offset = nxt;
            n_line_number = step_line_number;
            n_line_begin  = step_line_begin;
            n_key_start   = step_key_start;
            n_key_end     = step_key_end;
            n_arg_start   = step_arg_start;
            n_arg_last    = step_arg_last;
        end

        n_wr_ptr = r_wr_ptr + PTR_W'(in_acc && res0_v) + PTR_W'(in_acc && res1_v);
        n_rd_ptr = r_rd_ptr + PTR_W'(out_acc);
        n_count  = r_count + CNT_W'(in_acc && res0_v) + CNT_W'(in_acc && res1_v)
                 - CNT_W'(out_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_PRE;
            r_byte_offset <= '0;
            r_line_number <= OFFSET_W'(1);
            r_line_begin  <= '0;
            r_key_start   <= '0;
            r_key_end     <= '0;
            r_arg_start   <= '0;
            r_arg_last    <= '0;
            r_wr_ptr      <= '0;
            r_rd_ptr      <= '0;
            r_count       <= '0;
        end else begin
            if (in_acc) begin
                r_mode        <= n_mode;
                r_byte_offset <= n_byte_offset;
                r_line_number <= n_line_number;
                r_line_begin  <= n_line_begin;
                r_key_start   <= n_key_start;
                r_key_end     <= n_key_end;
                r_arg_start   <= n_arg_start;
                r_arg_last    <= n_arg_last;
            end
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && res0_v) begin
            r_fifo[r_wr_ptr] <= res0;
        end
        if (in_acc && res1_v) begin
            r_fifo[r_wr_ptr + PTR_W'(1)] <= res1;
        end
    end

    assign o_result_kind  = r_fifo[r_rd_ptr].kind;
    assign o_key_begin    = r_fifo[r_rd_ptr].key_begin;
    assign o_key_finish   = r_fifo[r_rd_ptr].key_finish;
    assign o_arg_begin    = r_fifo[r_rd_ptr].arg_begin;
    assign o_arg_finish   = r_fifo[r_rd_ptr].arg_finish;
    assign o_error_code   = r_fifo[r_rd_ptr].code;
    assign o_error_line   = r_fifo[r_rd_ptr].line;
    assign o_error_column = r_fifo[r_rd_ptr].column;
    assign o_last_of_run  = r_fifo[r_rd_ptr].last;

    `KVLT_ASSERT(a_fifo_bound, i_clk, i_rst_n, r_count <= CNT_W'(FIFO_DEPTH), "result queue overrun")
    `KVLT_ASSERT(a_halt_quiet, i_clk, i_rst_n, (in_acc && r_mode == MODE_HALT) |-> !res0_v, "halted parse produced a result")
    `KVLT_ASSERT(a_done_last, i_clk, i_rst_n, (o_valid && o_result_kind == KIND_DONE) |-> o_last_of_run, "done record not last of run")
    `KVLT_ASSERT(a_offset_sat, i_clk, i_rst_n, r_byte_offset <= MAX_OFF && r_line_number <= MAX_OFF, "counter past saturation")
    `KVLT_ASSERT_NEXT(a_eof_reset, i_clk, i_rst_n, in_acc && i_final_byte, r_mode == MODE_PRE && r_byte_offset == '0, "state not restarted after end of file")

endmodule
